/* src/fpfcd_pkg.sv */
// Shared constants and controller/datapath handshake types for the
// FPort frame channel decoder. No dependencies.
package fpfcd_pkg;

  localparam int unsigned PAYLOAD_BYTES = 25;
  localparam int unsigned CHANNEL_COUNT = 16;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CH_W    = 11;
  localparam int unsigned IDX_W   = 4;
  localparam int unsigned CNT_W   = $clog2(PAYLOAD_BYTES);
  localparam int unsigned SKIP_W  = 9;
  localparam int unsigned SHIFT_W = PAYLOAD_BYTES * BYTE_W;

  localparam logic [BYTE_W-1:0] HDR_BYTE = 8'h7E;
  localparam logic [BYTE_W-1:0] ESC_BYTE = 8'h7D;
  localparam logic [BYTE_W-1:0] ESC_XOR  = 8'h20;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic gap_clr;
    logic load_len;
    logic load_skip;
    logic start_data;
    logic skip_dec;
    logic data_byte;
    logic emit_step;
  } fpfcd_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic hdr_hit;
    logic type_zero;
    logic skip_last;
    logic store_hit;
    logic count_last;
    logic ch_last;
    logic out_free;
  } fpfcd_sts_t;

endpackage

/* src/fpfcd_if.sv */
// Request and result channel interfaces for the FPort frame channel decoder.
// Depends on fpfcd_pkg.
interface fpfcd_in_if
  import fpfcd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] rx_byte;
  logic              frame_gap;

  modport source (output valid, output rx_byte, output frame_gap, input ready);
  modport sink   (input valid, input rx_byte, input frame_gap, output ready);
endinterface

interface fpfcd_out_if
  import fpfcd_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] channel_index;
  logic [CH_W-1:0]  channel_value;
  logic             last_channel;

  modport source (output valid, output channel_index, output channel_value,
                  output last_channel, input ready);
  modport sink   (input valid, input channel_index, input channel_value,
                  input last_channel, output ready);
endinterface

/* src/fport_frame_channel_decoder_unit.sv */
// FPort frame channel decoder, top level.
// Depends on fpfcd_pkg, fpfcd_if, fpfcd_ctrl and fpfcd_dp.
// Output: once the final payload byte is taken, the unpack phase loads channel
// 0 into the result register first, then one channel per cycle while the sink keeps up.
// Throughput: one request per cycle while parsing; a completed frame holds
// off requests until all 16 channels have been unpacked.
// Reset: asynchronous, active low; the parser restarts in header hunt.
module fport_frame_channel_decoder_unit
  import fpfcd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  fpfcd_in_if.sink    req_i,
  fpfcd_out_if.source res_o
);

  fpfcd_cmd_t cmd;
  fpfcd_sts_t sts;
  logic       in_ready;
  logic       in_fire;

  // a request is taken only outside the channel unpack phase
  assign req_i.ready = in_ready;
  assign in_fire     = req_i.valid && in_ready;

  // controller: header hunt, length, type, skip, payload and unpack phases
  fpfcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_fire_i   (in_fire),
    .frame_gap_i (req_i.frame_gap),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_ready_o  (in_ready)
  );

  // datapath: payload bytes shift in little-endian, channels shift out in
  // SBUS order, each 11-bit value landing in the result register
  fpfcd_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .rx_byte_i       (req_i.rx_byte),
    .out_ready_i     (res_o.ready),
    .sts_o           (sts),
    .out_valid_o     (res_o.valid),
    .channel_index_o (res_o.channel_index),
    .channel_value_o (res_o.channel_value),
    .last_channel_o  (res_o.last_channel)
  );

endmodule

/* src/fpfcd_ctrl.sv */
// Parser state machine for the FPort frame channel decoder.
// Depends on fpfcd_pkg; drives fpfcd_dp through fpfcd_cmd_t.
module fpfcd_ctrl
  import fpfcd_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_fire_i,
  input  logic       frame_gap_i,
  input  fpfcd_sts_t sts_i,
  output fpfcd_cmd_t cmd_o,
  output logic       in_ready_o
);

  localparam logic [2:0] ST_HUNT = 3'd0;
  localparam logic [2:0] ST_LEN  = 3'd1;
  localparam logic [2:0] ST_TYPE = 3'd2;
  localparam logic [2:0] ST_SKIP = 3'd3;
  localparam logic [2:0] ST_DATA = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;

  logic [2:0] state_q, state_d;

  assign in_ready_o = (state_q != ST_EMIT);

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    if (state_q == ST_EMIT) begin
      if (sts_i.out_free) begin
        cmd_o.emit_step = 1'b1;
        if (sts_i.ch_last) state_d = ST_HUNT;
      end
    end else if (in_fire_i) begin
      if (frame_gap_i) begin
        cmd_o.gap_clr = 1'b1;
        state_d       = ST_HUNT;
      end else begin
        unique case (state_q)
          ST_LEN: begin
            cmd_o.load_len = 1'b1;
            state_d        = ST_TYPE;
          end
          ST_TYPE: begin
            if (sts_i.type_zero) begin
              cmd_o.start_data = 1'b1;
              state_d          = ST_DATA;
            end else begin
              cmd_o.load_skip = 1'b1;
              state_d         = ST_SKIP;
            end
          end
          ST_SKIP: begin
            cmd_o.skip_dec = 1'b1;
            if (sts_i.skip_last) state_d = ST_HUNT;
          end
          ST_DATA: begin
            cmd_o.data_byte = 1'b1;
            if (sts_i.store_hit && sts_i.count_last) state_d = ST_EMIT;
          end
          default: begin
            // header hunt, unused codes fall back here too
            state_d = sts_i.hdr_hit ? ST_LEN : ST_HUNT;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HUNT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

/* src/fpfcd_dp.sv */
// Datapath for the FPort frame channel decoder: counters, escape flag,
// payload shift line and the result register. Depends on fpfcd_pkg.
module fpfcd_dp
  import fpfcd_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  fpfcd_cmd_t        cmd_i,
  input  logic [BYTE_W-1:0] rx_byte_i,
  input  logic              out_ready_i,
  output fpfcd_sts_t        sts_o,
  output logic              out_valid_o,
  output logic [IDX_W-1:0]  channel_index_o,
  output logic [CH_W-1:0]   channel_value_o,
  output logic              last_channel_o
);

  logic [BYTE_W-1:0]  len_q, len_d;
  logic [SKIP_W-1:0]  skip_q, skip_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic               esc_q, esc_d;
  logic [SHIFT_W-1:0] shift_q, shift_d;
  logic [IDX_W-1:0]   ch_q, ch_d;
  logic               out_valid_q, out_valid_d;
  logic [IDX_W-1:0]   idx_q;
  logic [CH_W-1:0]    val_q;
  logic               last_q;
  logic               store;
  logic [BYTE_W-1:0]  store_val;

  assign sts_o.hdr_hit    = (rx_byte_i == HDR_BYTE);
  assign sts_o.type_zero  = (rx_byte_i == '0);
  assign sts_o.skip_last  = (skip_q <= SKIP_W'(1));
  assign sts_o.store_hit  = esc_q || (rx_byte_i != ESC_BYTE);
  assign sts_o.count_last = (cnt_q == CNT_W'(PAYLOAD_BYTES - 1));
  assign sts_o.ch_last    = (ch_q == IDX_W'(CHANNEL_COUNT - 1));
  assign sts_o.out_free   = !out_valid_q || out_ready_i;

  assign store     = cmd_i.data_byte && sts_o.store_hit;
  assign store_val = esc_q ? (rx_byte_i ^ ESC_XOR) : rx_byte_i;

  always_comb begin
    len_d       = len_q;
    skip_d      = skip_q;
    cnt_d       = cnt_q;
    esc_d       = esc_q;
    shift_d     = shift_q;
    ch_d        = ch_q;
    out_valid_d = out_valid_q && !out_ready_i;

    if (cmd_i.gap_clr) begin
      cnt_d  = '0;
      esc_d  = 1'b0;
      skip_d = '0;
    end
    if (cmd_i.load_len)  len_d  = rx_byte_i;
    if (cmd_i.load_skip) skip_d = {1'b0, len_q} + SKIP_W'(2);
    if (cmd_i.skip_dec && (skip_q != '0)) skip_d = skip_q - SKIP_W'(1);
    if (cmd_i.start_data) begin
      cnt_d = '0;
      esc_d = 1'b0;
    end
    if (cmd_i.data_byte) begin
      // drop the escape marker itself, unescape the byte after it
      if (esc_q) esc_d = 1'b0;
      else if (rx_byte_i == ESC_BYTE) esc_d = 1'b1;
    end
    if (store) begin
      shift_d = {store_val, shift_q[SHIFT_W-1:BYTE_W]};
      cnt_d   = sts_o.count_last ? '0 : cnt_q + CNT_W'(1);
    end
    if (cmd_i.emit_step) begin
      // byte 0 sits below the read window; advance one channel per step
      shift_d     = {{CH_W{1'b0}}, shift_q[SHIFT_W-1:CH_W]};
      ch_d        = sts_o.ch_last ? '0 : ch_q + IDX_W'(1);
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q       <= '0;
      skip_q      <= '0;
      cnt_q       <= '0;
      esc_q       <= 1'b0;
      ch_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      len_q       <= len_d;
      skip_q      <= skip_d;
      cnt_q       <= cnt_d;
      esc_q       <= esc_d;
      ch_q        <= ch_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
    if (cmd_i.emit_step) begin
      idx_q  <= ch_q;
      val_q  <= shift_q[BYTE_W +: CH_W];
      last_q <= sts_o.ch_last;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign channel_index_o = idx_q;
  assign channel_value_o = val_q;
  assign last_channel_o  = last_q;

  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && last_q |-> idx_q == IDX_W'(CHANNEL_COUNT - 1))
    else $error("last channel flag on wrong channel index");

  a_emit_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit_step |=> out_valid_q)
    else $error("emit step did not load the result register");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(PAYLOAD_BYTES - 1))
    else $error("payload count out of range");

  a_frame_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store && sts_o.count_last |=> ch_q == '0 && cnt_q == '0)
    else $error("channel counter not at zero when a frame completes");

endmodule
